FILE: src/lpht_pkg.sv
// Package with the codes, widths and state type of the linear probing hash table.
package lpht_pkg;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 31;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 5;

  // Bits of the key handled by one step of the home slot reduction.
  localparam int MOD_DIGIT_W = 8;
  localparam int MOD_STEPS   = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEARCH = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE
  } state_t;

endpackage

FILE: src/lpht_if.sv
// Valid/ready channel interfaces for requests and results of the hash table.
interface lpht_in_if;
  import lpht_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [KEY_W-1:0]     key;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface lpht_out_if;
  import lpht_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [SLOT_W-1:0]         slot;
  logic signed [VALUE_W-1:0] found_value;

  modport source (output valid, output status, output slot, output found_value, input ready);
  modport sink   (input valid, input status, input slot, input found_value, output ready);
endinterface

FILE: src/lpht_ram.sv
// Generic single write port, single read port RAM with a registered read.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/linear_probe_hash_table_core.sv
// Top level of the linear probing hash table: control sequencer, slot memories and result register.
//
//   channel | direction | beat contents                      | handshake
//   --------+-----------+------------------------------------+-------------
//   in_ch   | input     | kind, key, value                   | valid/ready
//   out_ch  | output    | status, slot, found_value          | valid/ready
//
// A request is accepted, its key is reduced to its home slot and the slots are then probed,
// visiting P slots (1 to SLOTS); the probe loop issues one read of the slot memories per cycle.
// After reset the flag memory is swept clear, one slot per cycle, and no request is taken
// during that sweep. A new request may be taken while a result still waits on out_ch;
// probing of that request starts only once the result register is free.
module linear_probe_hash_table_core #(
  parameter int SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lpht_in_if.sink    in_ch,
  lpht_out_if.source out_ch
);
  import lpht_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [IW:0]   SLOTS_W  = (IW + 1)'(SLOTS);
  localparam int KSH_W = MOD_DIGIT_W * MOD_STEPS;
  localparam logic [1:0] LAST_STEP = 2'(MOD_STEPS - 1);

  // Control state.
  state_t        state_r, state_nxt;
  logic [IW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [1:0]    mod_cnt_r, mod_cnt_nxt;
  logic [IW-1:0] iss_pos_r, iss_pos_nxt;
  logic [IW-1:0] ev_pos_r, ev_pos_nxt;
  logic [IW-1:0] ev_cnt_r, ev_cnt_nxt;
  logic          ev_vld_r, ev_vld_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Request and result payload.
  kind_t                  kind_r, kind_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [VALUE_W-1:0]     value_r, value_nxt;
  logic [KSH_W-1:0]       ksh_r, ksh_nxt;
  logic [IW-1:0]          rem_r, rem_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic [VALUE_W-1:0]     out_fv_r, out_fv_nxt;

  // Memory ports.
  logic                     fl_we;
  logic [IW-1:0]            fl_waddr;
  logic [1:0]               fl_wdata;
  logic [1:0]               fl_q;
  logic                     dt_we;
  logic [KEY_W+VALUE_W-1:0] dt_wdata;
  logic [KEY_W+VALUE_W-1:0] dt_q;
  logic [IW-1:0]            raddr;

  // Probe decision on the slot whose read data arrives this cycle.
  logic          in_acc;
  logic          out_free;
  logic          finish;
  status_t       fin_status;
  logic [IW-1:0] fin_pos;
  logic [VALUE_W-1:0] fin_fv;
  logic          fin_wr_fl;
  logic [1:0]    fin_fl;
  logic          fin_wr_dt;
  logic          slot_used, slot_del, key_hit, last_probe;
  logic [IW+SLOT_W-1:0] slot_ext;

  // The flags word is {used, deleted}; the data word is {key, value}.
  lpht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_flags (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (raddr),
    .rdata (fl_q)
  );

  lpht_ram #(.WIDTH(KEY_W + VALUE_W), .DEPTH(SLOTS)) u_data (
    .clk   (clk),
    .we    (dt_we),
    .waddr (fin_pos),
    .wdata (dt_wdata),
    .raddr (raddr),
    .rdata (dt_q)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.found_value = signed'(out_fv_r);

  // Home slot reduction: MOD_DIGIT_W key bits per cycle, most significant first; the last digit
  // waits for a free result register. Remainders stay below SLOTS: one compare-subtract per bit.
  always_comb begin
    logic [IW:0]   t;
    logic [IW-1:0] r;
    r = rem_r;
    for (int i = 0; i < MOD_DIGIT_W; i++) begin
      t = {r, ksh_r[KSH_W-1-i]};
      if (t >= SLOTS_W) begin
        t = t - SLOTS_W;
      end
      r = t[IW-1:0];
    end
    rem_nxt = r;
  end

  // Evaluation of the slot read in the previous cycle.
  always_comb begin
    slot_used  = fl_q[1];
    slot_del   = fl_q[0];
    key_hit    = (dt_q[KEY_W+VALUE_W-1:VALUE_W] == key_r);
    last_probe = (ev_cnt_r == LAST_IDX);
    finish     = 1'b0;
    fin_status = STATUS_MISS;
    fin_pos    = ev_pos_r;
    fin_fv     = '0;
    fin_wr_fl  = 1'b0;
    fin_fl     = 2'b10;
    fin_wr_dt  = 1'b0;
    if (state_r == S_PROBE && ev_vld_r) begin
      if (kind_r == KIND_INSERT) begin
        // An insert takes the first never-used or deleted slot.
        if (!slot_used || slot_del) begin
          finish     = 1'b1;
          fin_status = STATUS_OK;
          fin_wr_fl  = 1'b1;
          fin_fl     = 2'b10;
          fin_wr_dt  = 1'b1;
        end else if (last_probe) begin
          finish     = 1'b1;
          fin_status = STATUS_FULL;
        end
      end else begin
        // Search and delete stop at a never-used slot and step over deleted ones.
        if (!slot_used) begin
          finish     = 1'b1;
          fin_status = STATUS_MISS;
        end else if (!slot_del && key_hit) begin
          finish     = 1'b1;
          fin_status = STATUS_OK;
          fin_fv     = dt_q[VALUE_W-1:0];
          if (kind_r == KIND_DELETE) begin
            fin_wr_fl = 1'b1;
            fin_fl    = 2'b11;
          end
        end else if (last_probe) begin
          finish     = 1'b1;
          fin_status = STATUS_MISS;
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_cnt_r == LAST_STEP && out_free) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    mod_cnt_nxt    = mod_cnt_r;
    iss_pos_nxt    = iss_pos_r;
    ev_pos_nxt     = ev_pos_r;
    ev_cnt_nxt     = ev_cnt_r;
    ev_vld_nxt     = 1'b0;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    ksh_nxt        = ksh_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_fv_nxt     = out_fv_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    raddr          = iss_pos_r;
    fl_we          = 1'b0;
    fl_waddr       = fin_pos;
    fl_wdata       = fin_fl;
    dt_we          = 1'b0;
    dt_wdata       = {key_r, value_r};
    slot_ext       = {{SLOT_W{1'b0}}, fin_pos};
    case (state_r)
      S_CLEAR: begin
        fl_we       = 1'b1;
        fl_waddr    = clr_cnt_r;
        fl_wdata    = 2'b00;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          // Kind three behaves as a search.
          case (in_ch.kind)
            KIND_INSERT: kind_nxt = KIND_INSERT;
            KIND_DELETE: kind_nxt = KIND_DELETE;
            default:     kind_nxt = KIND_SEARCH;
          endcase
          key_nxt     = in_ch.key;
          value_nxt   = $unsigned(in_ch.value);
          ksh_nxt     = KSH_W'(in_ch.key);
          mod_cnt_nxt = '0;
        end
      end
      S_MOD: begin
        if (mod_cnt_r != LAST_STEP) begin
          ksh_nxt     = ksh_r << MOD_DIGIT_W;
          mod_cnt_nxt = mod_cnt_r + 1'b1;
        end else if (out_free) begin
          iss_pos_nxt = rem_nxt;
          ev_cnt_nxt  = '0;
        end
      end
      S_PROBE: begin
        // One read is issued each cycle; its data is judged in the next cycle.
        iss_pos_nxt = (iss_pos_r == LAST_IDX) ? '0 : iss_pos_r + 1'b1;
        ev_pos_nxt  = iss_pos_r;
        ev_vld_nxt  = !finish;
        if (ev_vld_r) begin
          ev_cnt_nxt = ev_cnt_r + 1'b1;
        end
        if (finish) begin
          fl_we          = fin_wr_fl;
          dt_we          = fin_wr_dt;
          out_valid_nxt  = 1'b1;
          out_status_nxt = fin_status;
          out_slot_nxt   = (fin_status == STATUS_OK) ? slot_ext[SLOT_W-1:0] : '0;
          out_fv_nxt     = fin_fv;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      mod_cnt_r   <= '0;
      ev_cnt_r    <= '0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      ev_cnt_r    <= ev_cnt_nxt;
      ev_vld_r    <= ev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    value_r      <= value_nxt;
    ksh_r        <= ksh_nxt;
    iss_pos_r    <= iss_pos_nxt;
    ev_pos_r     <= ev_pos_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_fv_r     <= out_fv_nxt;
    if (state_r == S_IDLE) begin
      rem_r <= '0;
    end else if (state_r == S_MOD && mod_cnt_r != LAST_STEP) begin
      rem_r <= rem_nxt;
    end
  end

`ifndef SYNTH
  // A result is only produced into an empty result register.
  a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> !out_valid_r)
    else $error("result produced while result register busy");

  // Probing never judges more than SLOTS slots.
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && ev_vld_r && ev_cnt_r == LAST_IDX) |-> finish)
    else $error("probe ran past the last slot");

  // No request is taken during the clearing sweep.
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_acc)
    else $error("request accepted during clearing sweep");

  // Memory write addresses stay inside the table.
  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fl_we || dt_we) |-> (fl_waddr <= LAST_IDX))
    else $error("write address beyond table");

  // The home slot handed to the probe loop is a proper remainder.
  a_home_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && state_nxt == S_PROBE) |=> (iss_pos_r <= LAST_IDX))
    else $error("home slot out of range");
`endif

endmodule
